// ===== rtl/vcpr_pkg.sv =====
// Package with shared types and constants of the voice channel ramper.
`timescale 1ns / 1ps
package vcpr_pkg;
  localparam int unsigned AddrChannels = 16;
  localparam int unsigned DivSteps = 16;

  typedef enum logic [2:0] {
    REQ_OPEN   = 3'd0,
    REQ_CLOSE  = 3'd1,
    REQ_LOAD   = 3'd2,
    REQ_PRAMP  = 3'd3,
    REQ_VRAMP  = 3'd4,
    REQ_TICK   = 3'd5,
    REQ_RSVD6  = 3'd6,
    REQ_RSVD7  = 3'd7
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIV,
    ST_APPLY,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic setup;
    logic div_start;
    logic div_step;
    logic apply;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
  } sts_t;

  typedef struct packed {
    logic [3:0]  channel_out;
    logic        ok;
    logic [15:0] pitch_now;
    logic [6:0]  volume_now;
    logic        pitch_busy;
    logic        volume_busy;
  } result_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [3:0]  channel_index;
    logic [15:0] change_amount;
    logic [15:0] ramp_ticks;
    logic [15:0] start_pitch;
    logic [6:0]  start_volume;
  } request_t;
endpackage

// ===== rtl/vcpr_if.sv =====
// Valid/ready channel interface carrying one payload beat.
`timescale 1ns / 1ps
interface vcpr_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/vcpr_ctrl.sv =====
// Controller state machine sequencing one request at a time.
`timescale 1ns / 1ps
module vcpr_ctrl import vcpr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.setup = 1'b1;
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        if (sts.need_div) begin
          cmd.div_start = 1'b1;
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_APPLY;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_nxt = ST_APPLY;
      end
      ST_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        in_ready = out_ready;
        if (out_ready) begin
          if (in_valid) begin
            cmd.setup = 1'b1;
            state_nxt = ST_SETUP;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

// ===== rtl/vcpr_dp.sv =====
// Datapath with the channel table, ramp arithmetic and a restoring divider.
`timescale 1ns / 1ps
module vcpr_dp import vcpr_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  request_t req,
  input  cmd_t     cmd,
  output sts_t     sts,
  output result_t  res
);
  localparam int unsigned CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned NSRCH = (NUM_CHANNELS < AddrChannels) ? NUM_CHANNELS
                                                                : AddrChannels;

  logic [NUM_CHANNELS-1:0] in_use_r;
  logic [15:0] pv_r [NUM_CHANNELS];
  logic [6:0]  vv_r [NUM_CHANNELS];
  logic [15:0] ps_r [NUM_CHANNELS];
  logic [14:0] pe_r [NUM_CHANNELS], pes_r [NUM_CHANNELS];
  logic [14:0] pl_r [NUM_CHANNELS], pp_r [NUM_CHANNELS];
  logic        psg_r [NUM_CHANNELS];
  logic [7:0]  vs_r [NUM_CHANNELS];
  logic [14:0] ve_r [NUM_CHANNELS], ves_r [NUM_CHANNELS];
  logic [14:0] vl_r [NUM_CHANNELS], vp_r [NUM_CHANNELS];
  logic        vsg_r [NUM_CHANNELS];

  request_t    rq_r;
  logic signed [16:0] amt_r;
  logic [14:0] n_r;
  logic [15:0] mag_r;
  logic [15:0] quo_r;
  logic [15:0] rem_r;
  logic [4:0]  cnt_r;
  result_t     res_r;
  assign res = res_r;

  logic [15:0] tk_abs;
  logic [14:0] tk_n;
  logic [CW-1:0] ch;
  logic ch_ok;
  logic signed [16:0] amt_c;
  logic signed [16:0] vext;
  logic signed [8:0] vsum;

  always_comb begin
    tk_abs = req.ramp_ticks[15] ? (16'd0 - req.ramp_ticks) : req.ramp_ticks;
    tk_n = tk_abs[15] ? 15'h7fff : tk_abs[14:0];
  end

  assign ch = CW'(rq_r.channel_index);
  assign ch_ok = {3'b000, rq_r.channel_index} < 7'(NUM_CHANNELS);

  always_comb begin
    vext = signed'({10'd0, vv_r[ch]});
    amt_c = amt_r;
    vsum = 9'(signed'({2'b00, vv_r[ch]})) + 9'(amt_r);
    if (rq_r.req_type == REQ_VRAMP) begin
      if (!amt_r[16] && amt_r != 0 && (amt_r + vext) >= 17'sd128) amt_c = 17'sd127 - vext;
      if (amt_r[16] && (amt_r + vext) < 17'sd0) amt_c = -vext;
    end
    vsum = 9'(amt_c);
  end

  assign sts.need_div = ch_ok && n_r != 0 &&
      (rq_r.req_type == REQ_PRAMP || rq_r.req_type == REQ_VRAMP);
  assign sts.div_done = cnt_r == 5'(DivSteps - 1);

  logic [16:0] trial;
  assign trial = {rem_r, mag_r[15]} - {2'b00, n_r};

  logic found;
  logic [CW-1:0] fidx;
  always_comb begin
    found = 1'b0;
    fidx = '0;
    for (int i = NSRCH - 1; i >= 0; i--) begin
      if (!in_use_r[i]) begin
        found = 1'b1;
        fidx = CW'(i);
      end
    end
  end

  logic [15:0] qs, rs;
  logic [16:0] pnext;
  logic [15:0] psum, esum;
  logic [15:0] vesum;
  logic signed [10:0] vnext;
  always_comb begin
    qs = amt_c[16] ? (16'd0 - quo_r) : quo_r;
    rs = rem_r;
    esum = {1'b0, pe_r[ch]} + {1'b0, pes_r[ch]};
    psum = pv_r[ch] + ps_r[ch];
    pnext = {1'b0, psum};
    if (esum >= {1'b0, pp_r[ch]}) begin
      pnext = {1'b0, psg_r[ch] ? psum - 16'd1 : psum + 16'd1};
      esum = esum - {1'b0, pp_r[ch]};
    end
    vesum = {1'b0, ve_r[ch]} + {1'b0, ves_r[ch]};
    vnext = 11'(signed'({1'b0, vv_r[ch]})) + 11'(signed'(vs_r[ch]));
    if (vesum >= {1'b0, vp_r[ch]}) begin
      vnext = vsg_r[ch] ? vnext - 11'sd1 : vnext + 11'sd1;
      vesum = vesum - {1'b0, vp_r[ch]};
    end
    if (vnext < 0) vnext = 0;
    if (vnext > 11'sd127) vnext = 11'sd127;
  end

  always_ff @(posedge clk) begin
    result_t     r_o;
    logic [15:0] p_o;
    logic [6:0]  v_o;
    logic        pb, vb;
    if (cmd.setup) begin
      rq_r <= req;
      amt_r <= 17'(signed'(req.change_amount));
      n_r <= tk_n;
    end
    if (cmd.div_start) begin
      mag_r <= amt_c[16] ? 16'(-amt_c) : 16'(amt_c);
      rem_r <= '0;
      quo_r <= '0;
      cnt_r <= '0;
    end
    if (cmd.div_step) begin
      mag_r <= {mag_r[14:0], 1'b0};
      if (!trial[16]) begin
        rem_r <= trial[15:0];
        quo_r <= {quo_r[14:0], 1'b1};
      end else begin
        rem_r <= {rem_r[14:0], mag_r[15]};
        quo_r <= {quo_r[14:0], 1'b0};
      end
      cnt_r <= cnt_r + 5'd1;
    end
    if (!rst_n) begin
      in_use_r <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        pv_r[i] <= '0; vv_r[i] <= '0; ps_r[i] <= '0; pe_r[i] <= '0;
        pes_r[i] <= '0; pl_r[i] <= '0; pp_r[i] <= '0; psg_r[i] <= 1'b0;
        vs_r[i] <= '0; ve_r[i] <= '0; ves_r[i] <= '0; vl_r[i] <= '0;
        vp_r[i] <= '0; vsg_r[i] <= 1'b0;
      end
    end else if (cmd.apply) begin
      r_o = '0;
      r_o.channel_out = rq_r.channel_index;
      p_o = pv_r[ch]; v_o = vv_r[ch];
      pb = pl_r[ch] != 0; vb = vl_r[ch] != 0;
      if (rq_r.req_type == REQ_OPEN) begin
        if (found) begin
          in_use_r[fidx] <= 1'b1;
          pl_r[fidx] <= '0;
          vl_r[fidx] <= '0;
          r_o.channel_out = 4'(fidx);
          r_o.ok = 1'b1;
          r_o.pitch_now = pv_r[fidx];
          r_o.volume_now = vv_r[fidx];
        end else begin
          r_o.channel_out = '0;
        end
      end else if (ch_ok) begin
        unique case (rq_r.req_type)
          REQ_CLOSE: in_use_r[ch] <= 1'b0;
          REQ_LOAD: begin
            p_o = rq_r.start_pitch; v_o = rq_r.start_volume;
          end
          REQ_PRAMP: begin
            if (n_r != 0) begin
              ps_r[ch] <= qs; pes_r[ch] <= rs[14:0]; pe_r[ch] <= '0;
              psg_r[ch] <= amt_c[16]; pl_r[ch] <= n_r; pp_r[ch] <= n_r;
              pb = 1'b1;
            end else begin
              pb = 1'b0;
              p_o = pv_r[ch] + amt_c[15:0];
            end
          end
          REQ_VRAMP: begin
            if (n_r != 0) begin
              vs_r[ch] <= qs[7:0]; ves_r[ch] <= rs[14:0]; ve_r[ch] <= '0;
              vsg_r[ch] <= amt_c[16]; vl_r[ch] <= n_r; vp_r[ch] <= n_r;
              vb = 1'b1;
            end else begin
              vb = 1'b0;
              v_o = 7'(vv_r[ch] + vsum[6:0]);
            end
          end
          REQ_TICK: begin
            if (pl_r[ch] != 0) begin
              p_o = pnext[15:0];
              pe_r[ch] <= esum[14:0];
              pl_r[ch] <= pl_r[ch] - 15'd1;
              pb = pl_r[ch] != 15'd1;
            end
            if (vl_r[ch] != 0) begin
              v_o = vnext[6:0];
              ve_r[ch] <= vesum[14:0];
              vl_r[ch] <= vl_r[ch] - 15'd1;
              vb = vl_r[ch] != 15'd1;
            end
          end
          default: ;
        endcase
        if (rq_r.req_type == REQ_PRAMP || rq_r.req_type == REQ_VRAMP)
          if (n_r == 0 && rq_r.req_type == REQ_PRAMP) pl_r[ch] <= '0;
        if (rq_r.req_type == REQ_VRAMP && n_r == 0) vl_r[ch] <= '0;
        pv_r[ch] <= p_o;
        vv_r[ch] <= v_o;
        r_o.ok = 1'b1;
        r_o.pitch_now = p_o;
        r_o.volume_now = v_o;
        r_o.pitch_busy = pb;
        r_o.volume_busy = vb;
      end
      res_r <= r_o;
    end
  end
endmodule

// ===== rtl/voice_channel_pitch_volume_ramper.sv =====
// Top level of the voice channel pitch and volume ramper.
// Requests are taken one at a time. Open, close, load, tick and ramps with a zero
// tick count pass through the setup, apply and output states; a ramp with a nonzero
// tick count on a valid channel also runs the bit-per-cycle restoring divider that
// forms step and remainder between setup and apply. The next request is accepted
// in the cycle its predecessor's result is taken.
`timescale 1ns / 1ps
module voice_channel_pitch_volume_ramper import vcpr_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = 16
) (
  input logic clk,
  input logic rst_n,
  vcpr_if.sink   in_ch,
  vcpr_if.source out_ch
);
  cmd_t cmd;
  sts_t sts;

  vcpr_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .sts, .cmd
  );

  vcpr_dp #(.NUM_CHANNELS(NUM_CHANNELS)) u_dp (
    .clk, .rst_n, .req(in_ch.data), .cmd, .sts, .res(out_ch.data)
  );

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.apply && (cmd.setup || cmd.div_step))) else $error("command overlap");
  a_apply_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.apply |=> out_ch.valid) else $error("result not shown after apply");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> !in_ch.ready) else $error("accept during divide");
endmodule
